FILE: hdl/rdp_pkg.sv
package rdp_pkg;

    localparam int TABLE_ENTRIES  = 64;
    localparam int THREAD_ID_BITS = 22;
    localparam int TIME_BITS      = 64;
    localparam int STATE_BITS     = 8;
    localparam int DELAY_BITS     = 31;
    localparam int IDX_W          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W          = $clog2(TABLE_ENTRIES + 1);

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    localparam logic OP_WAKEUP = 1'b0;
    localparam logic OP_SWITCH = 1'b1;

    typedef logic [THREAD_ID_BITS-1:0] tid_t;
    typedef logic [TIME_BITS-1:0]      stamp_t;
    typedef logic [IDX_W-1:0]          idx_t;

    typedef struct packed {
        logic                  opcode;
        stamp_t                event_time;
        tid_t                  thread_id;
        tid_t                  outgoing_thread;
        logic [STATE_BITS-1:0] outgoing_state;
    } rdp_in_t;

    typedef struct packed {
        stamp_t                switch_time;
        tid_t                  incoming_thread;
        tid_t                  outgoing_id;
        logic [DELAY_BITS-1:0] wait_time;
    } rdp_out_t;

    typedef struct packed {
        logic rd_en;
        logic start;
        idx_t addr;
        tid_t key;
    } rdp_scan_t;

    typedef struct packed {
        logic   wr_en;
        logic   clr_en;
        idx_t   addr;
        tid_t   key;
        stamp_t stamp;
    } rdp_wr_t;

    typedef struct packed {
        logic   hit;
        idx_t   hit_idx;
        stamp_t hit_stamp;
        logic   free;
        idx_t   free_idx;
    } rdp_stat_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_CLR,
        ALU_SUB,
        ALU_ADD
    } rdp_alu_op_t;

endpackage

FILE: hdl/rdp_table.sv
module rdp_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  rdp_pkg::rdp_scan_t scan,
    input  rdp_pkg::rdp_wr_t   wr,
    output rdp_pkg::rdp_stat_t stat
);
    import rdp_pkg::*;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    tid_t   key_mem   [TABLE_ENTRIES];
    stamp_t stamp_mem [TABLE_ENTRIES];

    logic   pend_reg;
    logic   vq_reg;
    idx_t   idx_reg;
    tid_t   kq_reg;
    stamp_t sq_reg;

    logic   hit_reg;
    idx_t   hit_idx_reg;
    stamp_t hit_stamp_reg;
    logic   free_reg;
    idx_t   free_idx_reg;

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            key_mem[wr.addr]   <= wr.key;
            stamp_mem[wr.addr] <= wr.stamp;
        end
        if (scan.rd_en) begin
            kq_reg  <= key_mem[scan.addr];
            sq_reg  <= stamp_mem[scan.addr];
            vq_reg  <= valid_reg[scan.addr];
            idx_reg <= scan.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end else begin
            pend_reg <= scan.rd_en;
            if (wr.wr_en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (wr.clr_en) begin
                valid_reg[wr.addr] <= 1'b0;
            end
            if (scan.start) begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else if (pend_reg) begin
                if (vq_reg && (kq_reg == scan.key) && !hit_reg) begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= idx_reg;
                    hit_stamp_reg <= sq_reg;
                end
                if (!vq_reg && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
            end
        end
    end

    assign stat.hit       = hit_reg;
    assign stat.hit_idx   = hit_idx_reg;
    assign stat.hit_stamp = hit_stamp_reg;
    assign stat.free      = free_reg;
    assign stat.free_idx  = free_idx_reg;

endmodule

FILE: hdl/rdp_alu.sv
module rdp_alu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rdp_pkg::rdp_alu_op_t op,
    input  rdp_pkg::stamp_t      a,
    input  rdp_pkg::stamp_t      b,
    output rdp_pkg::stamp_t      acc
);
    import rdp_pkg::*;

    stamp_t acc_reg;
    stamp_t acc_next;
    stamp_t tmp_reg;
    stamp_t tmp_next;
    stamp_t x;
    stamp_t y;
    logic   cin;
    stamp_t sum;

    always_comb begin
        x   = acc_reg;
        y   = tmp_reg;
        cin = 1'b0;
        if (op == ALU_SUB) begin
            x   = a;
            y   = ~b;
            cin = 1'b1;
        end
        sum = x + y + stamp_t'(cin);
    end

    always_comb begin
        acc_next = acc_reg;
        tmp_next = tmp_reg;
        unique case (op)
            ALU_CLR: acc_next = '0;
            ALU_SUB: tmp_next = sum;
            ALU_ADD: acc_next = sum;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
        tmp_reg <= tmp_next;
    end

    assign acc = acc_reg;

endmodule

FILE: hdl/runnable_delay_pairing.sv
// Runnable delay pairing: pairs scheduler wakeup and switch events.
// Input channel s_valid/s_ready/s_data carries one event per item: a wakeup
// (no result) or a context switch (one result on m_valid/m_ready/m_data).
// Two tables of TABLE_ENTRIES slots (thread id -> stamp) are searched by a
// serial scan, one slot per cycle through a registered memory read.
// Steps per item:
//   wakeup: scan, then insert.
//   switch: parallel scan of both tables, then two subtract/accumulate passes
//           of the shared 64-bit adder, then the result; then a scan and insert
//           of the preempt table when the outgoing thread is recorded as preempted.
// The slot scan sets the rate; s_ready is high only between items.
// A result sits in the output register until taken; if it is still held when
// the next result is ready, the sequencer waits there and s_ready stays low.
// Reset (aresetn low, synchronous) empties both tables at once and drops any
// pending item or result; the block is ready in the cycle after reset.
module runnable_delay_pairing (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rdp_pkg::rdp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rdp_pkg::rdp_out_t m_data
);
    import rdp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WSCAN,
        S_WPUT,
        S_LSCAN,
        S_WDIFF,
        S_WACC,
        S_PDIFF,
        S_PACC,
        S_OUT,
        S_PSCAN,
        S_PPUT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    rdp_in_t            item_reg;
    rdp_in_t            item_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    rdp_out_t           m_data_reg;
    rdp_out_t           m_data_next;

    rdp_scan_t          wake_scan;
    rdp_scan_t          pre_scan;
    rdp_wr_t            wake_wr;
    rdp_wr_t            pre_wr;
    rdp_stat_t          wake_stat;
    rdp_stat_t          pre_stat;
    rdp_alu_op_t        alu_op;
    stamp_t             alu_b;
    stamp_t             acc;

    logic               issue;
    logic               scan_done;
    logic               out_free;
    logic [DELAY_BITS-1:0] delay_sat;

    rdp_table u_wake (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scan    (wake_scan),
        .wr      (wake_wr),
        .stat    (wake_stat)
    );

    rdp_table u_preempt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scan    (pre_scan),
        .wr      (pre_wr),
        .stat    (pre_stat)
    );

    rdp_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (alu_op),
        .a       (item_reg.event_time),
        .b       (alu_b),
        .acc     (acc)
    );

    assign issue     = (cnt_reg != CNT_W'(TABLE_ENTRIES));
    assign scan_done = !issue;
    assign out_free  = !m_valid_reg || m_ready;
    assign delay_sat = (|acc[TIME_BITS-1:DELAY_BITS]) ? DELAY_MAX : acc[DELAY_BITS-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        wake_scan.rd_en = issue && ((state_reg == S_WSCAN) || (state_reg == S_LSCAN));
        wake_scan.start = wake_scan.rd_en && (cnt_reg == '0);
        wake_scan.addr  = cnt_reg[IDX_W-1:0];
        wake_scan.key   = item_reg.thread_id;

        pre_scan.rd_en  = issue && ((state_reg == S_LSCAN) || (state_reg == S_PSCAN));
        pre_scan.start  = pre_scan.rd_en && (cnt_reg == '0);
        pre_scan.addr   = cnt_reg[IDX_W-1:0];
        pre_scan.key    = (state_reg == S_PSCAN) ? item_reg.outgoing_thread
                                                 : item_reg.thread_id;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        item_next    = item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        alu_op       = ALU_IDLE;
        alu_b        = item_reg.event_time;

        wake_wr.wr_en  = 1'b0;
        wake_wr.clr_en = 1'b0;
        wake_wr.addr   = wake_stat.hit ? wake_stat.hit_idx : wake_stat.free_idx;
        wake_wr.key    = item_reg.thread_id;
        wake_wr.stamp  = item_reg.event_time;

        pre_wr.wr_en   = 1'b0;
        pre_wr.clr_en  = 1'b0;
        pre_wr.addr    = pre_stat.hit ? pre_stat.hit_idx : pre_stat.free_idx;
        pre_wr.key     = item_reg.outgoing_thread;
        pre_wr.stamp   = item_reg.event_time;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = (s_data.opcode == OP_SWITCH) ? S_LSCAN : S_WSCAN;
                end
            end
            S_WSCAN, S_PSCAN: begin
                if (scan_done) begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_WSCAN) ? S_WPUT : S_PPUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LSCAN: begin
                alu_op = ALU_CLR;
                if (scan_done) begin
                    cnt_next   = '0;
                    state_next = S_WDIFF;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WPUT: begin
                wake_wr.wr_en = wake_stat.hit || wake_stat.free;
                state_next    = S_IDLE;
            end
            S_WDIFF: begin
                alu_op     = ALU_SUB;
                alu_b      = wake_stat.hit ? wake_stat.hit_stamp : item_reg.event_time;
                state_next = S_WACC;
            end
            S_WACC: begin
                alu_op     = ALU_ADD;
                state_next = S_PDIFF;
            end
            S_PDIFF: begin
                alu_op     = ALU_SUB;
                alu_b      = pre_stat.hit ? pre_stat.hit_stamp : item_reg.event_time;
                state_next = S_PACC;
            end
            S_PACC: begin
                alu_op     = ALU_ADD;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.switch_time     = item_reg.event_time;
                    m_data_next.incoming_thread = item_reg.thread_id;
                    m_data_next.outgoing_id     = item_reg.outgoing_thread;
                    m_data_next.wait_time       = delay_sat;
                    wake_wr.clr_en              = wake_stat.hit;
                    wake_wr.addr                = wake_stat.hit_idx;
                    pre_wr.clr_en               = pre_stat.hit;
                    pre_wr.addr                 = pre_stat.hit_idx;
                    if ((item_reg.outgoing_state == '0) &&
                        (item_reg.outgoing_thread != '0)) begin
                        state_next = S_PSCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PPUT: begin
                pre_wr.wr_en = pre_stat.hit || pre_stat.free;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rdp_pkg::*;

    localparam int   WAKE_TBL     = 0;
    localparam int   PREEMPT_TBL  = 1;
    localparam int   POOL_SIZE    = 24;
    localparam int   STALL_LIMIT  = 20000;
    localparam int   DRAIN_CYCLES = 2 * TABLE_ENTRIES + 16;
    localparam tid_t MAX_TID      = '1;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rdp_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rdp_out_t m_data;

    bit       slot_used [2][TABLE_ENTRIES];
    tid_t     slot_tid  [2][TABLE_ENTRIES];
    stamp_t   slot_at   [2][TABLE_ENTRIES];
    rdp_out_t pending_pairings[$];

    tid_t     thread_pool[POOL_SIZE];
    tid_t     running_tid    = '0;
    stamp_t   now_ns         = '0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_len       = 0;
    int       hold_token     = 0;
    int       hold_seen      = 0;
    int       hold_left      = 0;
    int       idle_cycles    = 0;
    int       error_count    = 0;

    runnable_delay_pairing u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int find_slot(input int tbl, input tid_t id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[tbl][i] && slot_tid[tbl][i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void record_stamp(input int tbl, input tid_t id, input stamp_t at);
        int idx;
        idx = find_slot(tbl, id);
        if (idx < 0) begin
            for (int i = 0; i < TABLE_ENTRIES && idx < 0; i++) begin
                if (!slot_used[tbl][i]) idx = i;
            end
            if (idx < 0) return;
            slot_used[tbl][idx] = 1'b1;
            slot_tid[tbl][idx]  = id;
        end
        slot_at[tbl][idx] = at;
    endfunction

    function automatic void pair_event(input rdp_in_t ev);
        rdp_out_t res;
        stamp_t   waited;
        int       w;
        int       p;
        if (ev.opcode == OP_WAKEUP) begin
            record_stamp(WAKE_TBL, ev.thread_id, ev.event_time);
            return;
        end
        waited = '0;
        w = find_slot(WAKE_TBL, ev.thread_id);
        p = find_slot(PREEMPT_TBL, ev.thread_id);
        if (w >= 0) begin
            waited = ev.event_time - slot_at[WAKE_TBL][w];
            slot_used[WAKE_TBL][w] = 1'b0;
        end
        if (p >= 0) begin
            waited = waited + (ev.event_time - slot_at[PREEMPT_TBL][p]);
            slot_used[PREEMPT_TBL][p] = 1'b0;
        end
        res.switch_time     = ev.event_time;
        res.incoming_thread = ev.thread_id;
        res.outgoing_id     = ev.outgoing_thread;
        res.wait_time       = (waited > stamp_t'(DELAY_MAX)) ? DELAY_MAX
                                                             : waited[DELAY_BITS-1:0];
        pending_pairings.push_back(res);
        if (ev.outgoing_state == '0 && ev.outgoing_thread != '0) begin
            record_stamp(PREEMPT_TBL, ev.outgoing_thread, ev.event_time);
        end
    endfunction

    function automatic rdp_in_t make_event(input logic op, input stamp_t at, input tid_t tid,
                                           input tid_t out_tid, input logic [7:0] st);
        rdp_in_t ev;
        ev.opcode          = op;
        ev.event_time      = at;
        ev.thread_id       = tid;
        ev.outgoing_thread = out_tid;
        ev.outgoing_state  = st;
        return ev;
    endfunction

    function automatic tid_t pool_pick();
        return thread_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic rdp_in_t random_event();
        rdp_in_t ev;
        int      pick;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0) begin
            now_ns = now_ns + (stamp_t'($urandom) << $urandom_range(20));
        end else begin
            now_ns = now_ns + stamp_t'($urandom_range(20000, 1));
        end
        ev.opcode          = ($urandom_range(99) < 45) ? OP_WAKEUP : OP_SWITCH;
        ev.event_time      = now_ns;
        ev.thread_id       = pool_pick();
        ev.outgoing_thread = pool_pick();
        ev.outgoing_state  = 8'($urandom);
        if (pick < 85) begin
            if (ev.opcode == OP_SWITCH) begin
                ev.outgoing_thread = running_tid;
                ev.outgoing_state  = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : '0;
                running_tid        = ev.thread_id;
            end
        end else if (pick < 95) begin
            ev.event_time = {$urandom, $urandom};
        end else begin
            ev.event_time = now_ns - stamp_t'($urandom_range(50000));
        end
        return ev;
    endfunction

    task automatic send_event(input rdp_in_t ev);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pair_event(ev);
    endtask

    task automatic go_quiet();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pairings.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_event(make_event(OP_SWITCH, 64'd100, 22'd5, '0, '0));
        send_event(make_event(OP_WAKEUP, 64'd1000, '0, MAX_TID, 8'hFF));
        send_event(make_event(OP_SWITCH, 64'd1500, '0, MAX_TID, '0));
        send_event(make_event(OP_WAKEUP, 64'd2000, MAX_TID, '0, '0));
        send_event(make_event(OP_WAKEUP, 64'd2600, MAX_TID, '0, '0));
        send_event(make_event(OP_SWITCH, 64'd3000, MAX_TID, 22'd7, 8'hFF));
        send_event(make_event(OP_SWITCH, 64'd3100, 22'd7, 22'd7, '0));
        send_event(make_event(OP_SWITCH, 64'd3400, 22'd7, 22'd7, '0));
        send_event(make_event(OP_SWITCH, 64'd3500, 22'd7, 22'd9, 8'h01));
        send_event(make_event(OP_WAKEUP, 64'hFFFF_FFFF_FFFF_FF00, 22'd9, '0, '0));
        send_event(make_event(OP_SWITCH, 64'h100, 22'd9, '0, '0));
        send_event(make_event(OP_WAKEUP, 64'd5000, 22'd11, '0, '0));
        send_event(make_event(OP_SWITCH, 64'd4000, 22'd11, '0, '0));
        send_event(make_event(OP_WAKEUP, 64'd0, 22'd12, '0, '0));
        send_event(make_event(OP_SWITCH, 64'h8000_0000, 22'd12, '0, '0));
        send_event(make_event(OP_WAKEUP, 64'd0, 22'd13, '0, '0));
        send_event(make_event(OP_SWITCH, 64'h7FFF_FFFF, 22'd13, '0, '0));
        send_event(make_event(OP_WAKEUP, 64'd10, 22'd14, '0, '0));
        send_event(make_event(OP_SWITCH, 64'd20, 22'd15, 22'd14, '0));
        send_event(make_event(OP_SWITCH, 64'h4000_0020, 22'd14, 22'd3, 8'h80));
        send_event(make_event(OP_SWITCH, 64'h4000_0030, 22'd3, 22'd3, 8'h80));
        send_event(make_event(OP_SWITCH, '1, 22'h2AAAAA, 22'h155555, '0));
        send_event(make_event(OP_SWITCH, 64'd77, 22'h155555, 22'h2AAAAA, '0));
        go_quiet();
        wait_drained();
    endtask

    task automatic test_table_overflow();
        tid_t base;
        base = 22'h300000;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < TABLE_ENTRIES + 6; i++) begin
            now_ns = now_ns + 64'd50;
            send_event(make_event(OP_WAKEUP, now_ns, tid_t'(base + i), '0, '0));
        end
        for (int i = 0; i < TABLE_ENTRIES + 6; i++) begin
            now_ns = now_ns + 64'd50;
            send_event(make_event(OP_SWITCH, now_ns, tid_t'(base + i), '0, '0));
        end
        for (int i = 0; i < TABLE_ENTRIES + 6; i++) begin
            now_ns = now_ns + 64'd50;
            send_event(make_event(OP_SWITCH, now_ns, 22'd1, tid_t'(base + i), '0));
        end
        for (int i = 0; i < TABLE_ENTRIES + 6; i++) begin
            now_ns = now_ns + 64'd50;
            send_event(make_event(OP_SWITCH, now_ns, tid_t'(base + i), '0, 8'h02));
        end
        go_quiet();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_event(random_event());
        go_quiet();
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        rdp_in_t ev;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 1000;
        hold_token     = hold_token + 1;
        repeat (16) begin
            ev = random_event();
            ev.opcode = OP_SWITCH;
            send_event(ev);
        end
        go_quiet();
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        repeat (20) send_event(random_event());
        go_quiet();
        wait_drained();
        repeat (20) send_event(random_event());
        go_quiet();
        wait_drained();
    endtask

    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready   = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        rdp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairings.size() == 0) begin
                $error("unexpected result: switch_time %h incoming_thread %h",
                       m_data.switch_time, m_data.incoming_thread);
                error_count++;
            end else begin
                want = pending_pairings.pop_front();
                if (m_data.switch_time !== want.switch_time) begin
                    $error("switch_time: expected %h, actual %h",
                           want.switch_time, m_data.switch_time);
                    error_count++;
                end
                if (m_data.incoming_thread !== want.incoming_thread) begin
                    $error("incoming_thread: expected %h, actual %h",
                           want.incoming_thread, m_data.incoming_thread);
                    error_count++;
                end
                if (m_data.outgoing_id !== want.outgoing_id) begin
                    $error("outgoing_id: expected %h, actual %h",
                           want.outgoing_id, m_data.outgoing_id);
                    error_count++;
                end
                if (m_data.wait_time !== want.wait_time) begin
                    $error("wait_time: expected %0d, actual %0d",
                           want.wait_time, m_data.wait_time);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        thread_pool[0] = '0;
        thread_pool[1] = MAX_TID;
        for (int i = 2; i < POOL_SIZE; i++) thread_pool[i] = tid_t'($urandom);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_table_overflow();
        now_ns = 64'h10_0000_0000;
        test_random_traffic(250, 0, 0);
        test_random_traffic(250, 73, 0);
        test_output_backpressure();
        test_random_traffic(250, 0, 73);
        test_drain_pause();
        test_random_traffic(250, 16, 16);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_pairings.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
